// File: src/pal_pkg.sv
package pal_pkg;

  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned ENTRY_WIDTH = 32;

  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_TDATA_BITS  = POS_W + DATA_W;
  localparam int unsigned IN_TDATA_W     = ((IN_TDATA_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_BITS = DATA_W + COUNT_W;
  localparam int unsigned OUT_TDATA_W    = ((OUT_TDATA_BITS + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] CAPACITY_CNT = COUNT_W'(CAPACITY);

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_REM_HEAD = 3'd3,
    OP_REM_TAIL = 3'd4,
    OP_REM_POS  = 3'd5,
    OP_READ_POS = 3'd6
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_DONE
  } state_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   entry_in;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   entry_out;
    status_e             status;
    logic [COUNT_W-1:0]  count;
  } res_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [ENTRY_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

endpackage

// File: src/pal_ram.sv
module pal_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/pal_ctrl.sv
module pal_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  pal_pkg::req_t                   req_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output pal_pkg::res_t                   res_o,
  output pal_pkg::mem_req_t               mem_o,
  input  logic [pal_pkg::ENTRY_WIDTH-1:0] mem_rdata_i
);
  import pal_pkg::*;

  state_e                 state_q, state_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [ADDR_W-1:0]      ptr_q, ptr_d;
  logic [ADDR_W-1:0]      end_q, end_d;
  logic [ADDR_W-1:0]      at_q, at_d;
  logic                   up_q, up_d;
  logic                   ins_q, ins_d;
  logic [ENTRY_WIDTH-1:0] val_q, val_d;
  logic [DATA_W-1:0]      entry_q, entry_d;
  status_e                status_q, status_d;
  logic                   stg_valid_q, stg_valid_d;
  logic [ADDR_W-1:0]      stg_addr_q, stg_addr_d;

  logic [COUNT_W-1:0]     pos_ext;
  logic [COUNT_W-1:0]     at_ins;
  logic [COUNT_W-1:0]     at_rem;

  assign pos_ext = COUNT_W'(req_i.position);

  always_comb begin
    case (req_i.opcode)
      OP_INS_HEAD: at_ins = '0;
      OP_INS_TAIL: at_ins = count_q;
      default:     at_ins = pos_ext;
    endcase
    case (req_i.opcode)
      OP_REM_HEAD: at_rem = '0;
      OP_REM_TAIL: at_rem = count_q - COUNT_W'(1);
      default:     at_rem = pos_ext;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    end_q      <= end_d;
    at_q       <= at_d;
    up_q       <= up_d;
    ins_q      <= ins_d;
    val_q      <= val_d;
    entry_q    <= entry_d;
    status_q   <= status_d;
    stg_addr_q <= stg_addr_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    at_d        = at_q;
    up_d        = up_q;
    ins_d       = ins_q;
    val_d       = val_q;
    entry_d     = entry_q;
    status_d    = status_q;
    stg_valid_d = 1'b0;
    stg_addr_d  = stg_addr_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_o.we    = 1'b0;
    mem_o.waddr = stg_addr_q;
    mem_o.wdata = mem_rdata_i;
    mem_o.raddr = ptr_q;

    // read data from the previous cycle moves one slot, or is the taken entry
    if (stg_valid_q) begin
      if (!up_q) begin
        mem_o.we    = 1'b1;
        mem_o.waddr = stg_addr_q + ADDR_W'(1);
      end else if (stg_addr_q == at_q) begin
        entry_d = DATA_W'(mem_rdata_i);
      end else begin
        mem_o.we    = 1'b1;
        mem_o.waddr = stg_addr_q - ADDR_W'(1);
      end
    end

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          entry_d  = '0;
          status_d = STAT_OK;
          state_d  = S_DONE;
          val_d    = ENTRY_WIDTH'(req_i.entry_in);
          case (req_i.opcode)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
              if (count_q == CAPACITY_CNT) begin
                status_d = STAT_FULL;
              end else if (at_ins > count_q) begin
                status_d = STAT_RANGE;
              end else begin
                count_d = count_q + COUNT_W'(1);
                at_d    = at_ins[ADDR_W-1:0];
                ins_d   = 1'b1;
                up_d    = 1'b0;
                ptr_d   = ADDR_W'(count_q - COUNT_W'(1));
                end_d   = at_ins[ADDR_W-1:0];
                state_d = (at_ins == count_q) ? S_PUT : S_SHIFT;
              end
            end
            OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS, OP_READ_POS: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else if (at_rem >= count_q) begin
                status_d = STAT_RANGE;
              end else begin
                at_d    = at_rem[ADDR_W-1:0];
                ptr_d   = at_rem[ADDR_W-1:0];
                up_d    = 1'b1;
                ins_d   = 1'b0;
                state_d = S_SHIFT;
                if (req_i.opcode == OP_READ_POS) begin
                  end_d = at_rem[ADDR_W-1:0];
                end else begin
                  end_d   = ADDR_W'(count_q - COUNT_W'(1));
                  count_d = count_q - COUNT_W'(1);
                end
              end
            end
            default: begin
              status_d = STAT_OK;
            end
          endcase
        end
      end
      S_SHIFT: begin
        mem_o.raddr = ptr_q;
        stg_valid_d = 1'b1;
        stg_addr_d  = ptr_q;
        if (ptr_q == end_q) begin
          state_d = S_DRAIN;
        end else if (up_q) begin
          ptr_d = ptr_q + ADDR_W'(1);
        end else begin
          ptr_d = ptr_q - ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = ins_q ? S_PUT : S_DONE;
      end
      S_PUT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = at_q;
        mem_o.wdata = val_q;
        state_d     = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.entry_out = entry_q;
  assign res_o.status    = status_q;
  assign res_o.count     = count_q;

endmodule

// File: src/positional_array_list.sv
// channel   dir  tdata (low bit up)                  tuser          tlast
// s_axis    in   position[10:0], entry_in[42:11]     opcode[2:0]    -
// m_axis    out  entry_out[31:0], count[42:32]       status[1:0]    -
//
// one beat in gives one beat out; items are handled one at a time
// insert shifts the entries after the slot up and writes the new one, append
// writes it directly, remove shifts the entries after the slot down; the single
// write port of the entry memory moves one entry per cycle
// reset clears the count and control only, the entry memory is not cleared
// a stalled m_axis beat is held in the output register; the next s_axis beat is
// taken meanwhile and its result waits in the controller
module positional_array_list (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [pal_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,  // position, entry_in
  input  logic [pal_pkg::OPCODE_W-1:0]     s_axis_tuser_i,  // opcode
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [pal_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,  // entry_out, count
  output logic [pal_pkg::STATUS_W-1:0]     m_axis_tuser_o   // status
);
  import pal_pkg::*;

  req_t                   req;
  res_t                   res;
  logic                   res_valid;
  logic                   res_ready;
  mem_req_t               mem_req;
  logic [ENTRY_WIDTH-1:0] mem_rdata;

  logic                   out_valid_q;
  res_t                   out_q;

  assign req.opcode   = opcode_e'(s_axis_tuser_i);
  assign req.position = s_axis_tdata_i[POS_W-1:0];
  assign req.entry_in = s_axis_tdata_i[POS_W +: DATA_W];

  pal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  pal_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_q.count, out_q.entry_out});
  assign m_axis_tuser_o  = out_q.status;

endmodule

// File: src/pal_checker.sv
module pal_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [pal_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [pal_pkg::OPCODE_W-1:0]    s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [pal_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [pal_pkg::STATUS_W-1:0]    m_axis_tuser_o
);
  import pal_pkg::*;

  logic [COUNT_W-1:0] out_count;
  logic [DATA_W-1:0]  out_entry;

  assign out_count = m_axis_tdata_o[DATA_W +: COUNT_W];
  assign out_entry = m_axis_tdata_o[DATA_W-1:0];

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_count <= CAPACITY_CNT)
    else $error("count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_FULL |-> out_count == CAPACITY_CNT
      && out_entry == '0)
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_EMPTY |-> out_count == '0
      && out_entry == '0)
    else $error("empty status with entries present");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_RANGE |-> out_entry == '0)
    else $error("refused request returned an entry");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o
      && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output beat changed");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

// File: tb/pal_list_checker.sv
module pal_list_checker
  import pal_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  input  logic                    s_tready_i,
  input  logic [IN_TDATA_W-1:0]   s_tdata_i,   // position, entry_in
  input  logic [OPCODE_W-1:0]     s_tuser_i,   // opcode
  input  logic                    m_tvalid_i,
  input  logic                    m_tready_i,
  input  logic [OUT_TDATA_W-1:0]  m_tdata_i,   // entry_out, count
  input  logic [STATUS_W-1:0]     m_tuser_i,   // status
  output int                      errors_o,
  output int                      results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] mirror_list[$];
  res_t              due_results[$];
  int                mismatches = 0;

  assign errors_o = mismatches;

  task automatic report_mismatch(string msg);
    if (mismatches < 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // applies one request to the mirrored list and returns the beat it should produce
  function automatic res_t apply_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                         logic [DATA_W-1:0] val);
    res_t        r;
    int unsigned n;
    int unsigned at;
    r.entry_out = '0;
    r.status    = STAT_OK;
    n = mirror_list.size();
    case (op)
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
        at = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_TAIL) ? n : pos;
        // full wins over a bad position
        if (n >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (at > n) begin
          r.status = STAT_RANGE;
        end else begin
          mirror_list.insert(at, val);
        end
      end
      OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS, OP_READ_POS: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          at = (op == OP_REM_HEAD) ? 0 : (op == OP_REM_TAIL) ? n - 1 : pos;
          if (at >= n) begin
            r.status = STAT_RANGE;
          end else begin
            r.entry_out = mirror_list[at];
            if (op != OP_READ_POS) mirror_list.delete(at);
          end
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(mirror_list.size());
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    res_t got;
    res_t want;
    if (rst_ni) begin
      // output side first so a beat arriving with an empty queue is caught
      if (m_tvalid_i && m_tready_i) begin
        got.entry_out = m_tdata_i[DATA_W-1:0];
        got.count     = m_tdata_i[DATA_W +: COUNT_W];
        got.status    = status_e'(m_tuser_i);
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: entry %h status %0d count %0d",
                                    got.entry_out, got.status, got.count));
        end else begin
          want = due_results.pop_front();
          if (got.entry_out !== want.entry_out)
            report_mismatch($sformatf("entry_out got %h want %h", got.entry_out, want.entry_out));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        due_results.push_back(apply_request(s_tuser_i, s_tdata_i[POS_W-1:0],
                                            s_tdata_i[POS_W +: DATA_W]));
      end
    end
    results_due_o <= due_results.size();
  end

endmodule

// File: tb/positional_array_list_tb.sv
module positional_array_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;

  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = CAPACITY + 16;
  localparam int RANDOM_PER_PHASE = 170;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [OPCODE_W-1:0]    s_tuser = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]    m_axis_tuser_o;

  int check_errors;
  int results_due;
  int src_idle_pct = 6;
  int sink_idle_pct = 56;
  int requests_sent = 0;
  int quiet_cycles = 0;
  bit hold_tog = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  positional_array_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  pal_list_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_axis_tready_o),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_axis_tvalid_o),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_axis_tdata_o),
    .m_tuser_i     (m_axis_tuser_o),
    .errors_o      (check_errors),
    .results_due_o (results_due)
  );

  // receiver: random back-pressure, or a long hold-off each time hold_tog flips
  initial begin : sink
    bit hold_seen;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // returns at the edge where the beat is taken
  task automatic offer_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({val, pos});
    s_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic offer_random_request();
    int                  roll;
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    roll = $urandom_range(99);
    if      (roll < 15) op = OP_INS_HEAD;
    else if (roll < 30) op = OP_INS_TAIL;
    else if (roll < 45) op = OP_INS_POS;
    else if (roll < 58) op = OP_REM_HEAD;
    else if (roll < 71) op = OP_REM_TAIL;
    else if (roll < 85) op = OP_REM_POS;
    else if (roll < 97) op = OP_READ_POS;
    else                op = OP_UNUSED;
    // mostly positions near the head, now and then the whole field
    if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(2047));
    else                        pos = POS_W'($urandom_range(24));
    offer_request(op, pos, $urandom());
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, bad positions, unused opcode
    offer_request(OP_REM_HEAD, '0, '0);
    offer_request(OP_REM_TAIL, '1, '0);
    offer_request(OP_REM_POS, '0, '0);
    offer_request(OP_READ_POS, '0, '0);
    offer_request(OP_INS_POS, 11'd1, 32'h1);
    offer_request(OP_INS_POS, '1, '1);
    offer_request(OP_UNUSED, '1, '1);
    // build a short list: head, tail, middle, append at count, then an insert past the end
    offer_request(OP_INS_HEAD, '0, 32'hFFFF_FFFF);
    offer_request(OP_INS_TAIL, '1, 32'h0000_0000);
    offer_request(OP_INS_POS, 11'd1, 32'hA5A5_5A5A);
    offer_request(OP_INS_POS, 11'd3, 32'h1234_5678);
    offer_request(OP_INS_POS, 11'd5, 32'hDEAD_BEEF);
    for (int i = 0; i <= 4; i++) offer_request(OP_READ_POS, POS_W'(i), '0);
    offer_request(OP_READ_POS, 11'd1024, '0);
    offer_request(OP_REM_POS, 11'd1, '0);
    offer_request(OP_REM_POS, '1, '0);
    offer_request(OP_REM_HEAD, '0, '0);
    offer_request(OP_UNUSED, '0, '0);
    offer_request(OP_REM_TAIL, '0, '0);
    offer_request(OP_REM_POS, '0, '0);

    repeat (RANDOM_PER_PHASE) offer_random_request();
    wait_all_results();

    src_idle_pct = 56;
    sink_idle_pct <= 6;
    repeat (RANDOM_PER_PHASE) offer_random_request();
    wait_all_results();

    src_idle_pct = 0;
    sink_idle_pct <= 0;
    // a longer list so head inserts and removes shift many entries
    repeat (20) offer_request(OP_INS_TAIL, POS_W'($urandom()), $urandom());
    offer_request(OP_INS_HEAD, '0, $urandom());
    offer_request(OP_INS_POS, 11'd1024, $urandom());
    offer_request(OP_READ_POS, '0, '0);
    offer_request(OP_READ_POS, '1, '0);
    offer_request(OP_REM_HEAD, '0, '0);
    offer_request(OP_REM_POS, 11'd10, '0);

    // receiver holds off while beats keep coming, so the input side backs up
    hold_tog <= ~hold_tog;
    repeat (12) offer_random_request();
    wait_all_results();

    repeat (RANDOM_PER_PHASE) offer_random_request();
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d requests: empty, out-of-range and unused-opcode cases, all ops",
             requests_sent);
    $display("three idle mixes, long shifts and a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (check_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
src/pal_pkg.sv
src/pal_ram.sv
src/pal_ctrl.sv
src/positional_array_list.sv
src/pal_checker.sv
tb/pal_list_checker.sv
tb/positional_array_list_tb.sv
